// ===== rtl/sbe_pkg.sv =====
// Package for the stack bytecode executor: opcodes, status codes, select codes,
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package sbe_pkg;

  // Opcodes
  localparam logic [4:0] OP_NOP        = 5'd0;
  localparam logic [4:0] OP_END        = 5'd1;
  localparam logic [4:0] OP_PUSH_CONST = 5'd2;
  localparam logic [4:0] OP_PUSH_LVAL  = 5'd3;
  localparam logic [4:0] OP_PUSH_LADDR = 5'd4;
  localparam logic [4:0] OP_ASSIGN     = 5'd5;
  localparam logic [4:0] OP_ADD        = 5'd6;
  localparam logic [4:0] OP_SUB        = 5'd7;
  localparam logic [4:0] OP_MUL        = 5'd8;
  localparam logic [4:0] OP_DIV        = 5'd9;
  localparam logic [4:0] OP_MOD        = 5'd10;
  localparam logic [4:0] OP_SHL        = 5'd11;
  localparam logic [4:0] OP_SHR        = 5'd12;
  localparam logic [4:0] OP_OR         = 5'd13;
  localparam logic [4:0] OP_XOR        = 5'd14;
  localparam logic [4:0] OP_AND        = 5'd15;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_END     = 3'd1;
  localparam logic [2:0] ST_DIVZERO = 3'd2;
  localparam logic [2:0] ST_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_STACK   = 3'd4;
  localparam logic [2:0] ST_ADDR    = 3'd5;
  localparam logic [2:0] ST_HALTED  = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] CFG_STACK_BASE = 2'd0;
  localparam logic [1:0] CFG_FRAME_BASE = 2'd1;

  // Memory read address select
  localparam logic [1:0] RD_SP1   = 2'd0;  // top of stack
  localparam logic [1:0] RD_SP2   = 2'd1;  // second from top
  localparam logic [1:0] RD_LOCAL = 2'd2;  // frame base plus offset

  // Memory write address select
  localparam logic [1:0] WR_SP0 = 2'd0;    // next free slot
  localparam logic [1:0] WR_SP2 = 2'd1;    // second from top
  localparam logic [1:0] WR_A   = 2'd2;    // address popped by assign
  localparam logic [1:0] WR_CLR = 2'd3;    // clearing pass

  // Memory write data select
  localparam logic [2:0] WD_IMM   = 3'd0;
  localparam logic [2:0] WD_RD    = 3'd1;
  localparam logic [2:0] WD_LADDR = 3'd2;
  localparam logic [2:0] WD_B     = 3'd3;
  localparam logic [2:0] WD_ALU   = 3'd4;
  localparam logic [2:0] WD_ZERO  = 3'd5;

  // Stack pointer update
  localparam logic [1:0] SP_HOLD = 2'd0;
  localparam logic [1:0] SP_PUSH = 2'd1;
  localparam logic [1:0] SP_POP1 = 2'd2;
  localparam logic [1:0] SP_POP2 = 2'd3;

  typedef struct packed {
    logic       in_load;
    logic [4:0] op;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic [2:0] wd_sel;
    logic       cap_a;
    logic       cap_b;
    logic [1:0] sp_op;
    logic       md_start;
    logic       clr_step;
    logic       out_load;
    logic [2:0] out_status;
  } sbe_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic push_ovf;
    logic laddr_ok;
    logic depth_ge2;
    logic a_addr_ok;
    logic b_zero;
    logic md_done;
  } sbe_sts_t;

endpackage

`default_nettype wire

// ===== rtl/sbe_muldiv.sv =====
// Iterative multiply and signed divide/modulo unit, one bit per cycle.
// Depends on sbe_pkg for opcodes.
`default_nettype none

module sbe_muldiv import sbe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [4:0]  op,
  input  wire logic [63:0] opnd_a,
  input  wire logic [63:0] opnd_b,
  output logic             done,
  output logic [63:0]      result
);

  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [4:0]  op_r;
  logic        neg_q_r, neg_rem_r;
  logic [63:0] acc_r, opa_r, opb_r;
  logic [63:0] acc_nxt, opa_nxt, opb_nxt;
  logic [64:0] rem_try, diff;
  logic [63:0] mag_a, mag_b;

  assign mag_a = opnd_a[63] ? (64'd0 - opnd_a) : opnd_a;
  assign mag_b = opnd_b[63] ? (64'd0 - opnd_b) : opnd_b;

  assign rem_try = {acc_r, opa_r[63]};
  assign diff    = rem_try - {1'b0, opb_r};

  always_comb begin
    if (op_r == OP_MUL) begin
      // shift-add: add multiplicand where the multiplier bit is set
      acc_nxt = acc_r + (opb_r[0] ? opa_r : 64'd0);
      opa_nxt = {opa_r[62:0], 1'b0};
      opb_nxt = {1'b0, opb_r[63:1]};
    end else begin
      // restoring divide: quotient bits shift into opa
      acc_nxt = diff[64] ? rem_try[63:0] : diff[63:0];
      opa_nxt = {opa_r[62:0], ~diff[64]};
      opb_nxt = opb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r      <= op;
      acc_r     <= 64'd0;
      neg_q_r   <= opnd_a[63] ^ opnd_b[63];
      neg_rem_r <= opnd_a[63];
      if (op == OP_MUL) begin
        opa_r <= opnd_a;
        opb_r <= opnd_b;
      end else begin
        opa_r <= mag_a;
        opb_r <= mag_b;
      end
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      opa_r <= opa_nxt;
      opb_r <= opb_nxt;
    end
  end

  assign done = done_r;

  always_comb begin
    case (op_r)
      OP_MUL:  result = acc_r;
      OP_DIV:  result = neg_q_r ? (64'd0 - opa_r) : opa_r;
      default: result = neg_rem_r ? (64'd0 - acc_r) : acc_r;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sbe_ctrl.sv =====
// Controller state machine of the stack bytecode executor: sequences memory
// reads, writes, arithmetic and result delivery. Depends on sbe_pkg.
`default_nettype none

module sbe_ctrl import sbe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [4:0] in_op,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire sbe_sts_t   sts,
  output sbe_cmd_t        cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_LOC   = 4'd3;
  localparam logic [3:0] S_RD_A  = 4'd4;
  localparam logic [3:0] S_RD_B  = 4'd5;
  localparam logic [3:0] S_EXEC  = 4'd6;
  localparam logic [3:0] S_MD    = 4'd7;
  localparam logic [3:0] S_TOP   = 4'd8;
  localparam logic [3:0] S_TOPW  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [4:0] op_r, op_nxt;
  logic [2:0] status_r, status_nxt;
  logic       halted_r, halted_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    status_nxt = status_r;
    halted_nxt = halted_r;
    cmd        = '0;
    cmd.op     = op_r;
    cmd.out_status = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    unique case (state_r)
      S_CLEAR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = WR_CLR;
        cmd.wd_sel   = WD_ZERO;
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          op_nxt      = in_op;
          status_nxt  = ST_OK;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_TOP;
        if (halted_r) begin
          status_nxt = ST_HALTED;
        end else begin
          unique case (op_r) inside
            OP_NOP: ;
            OP_END: begin
              status_nxt = ST_END;
              halted_nxt = 1'b1;
            end
            OP_PUSH_CONST, OP_PUSH_LADDR: begin
              if (sts.push_ovf) begin
                status_nxt = ST_STACK;
                halted_nxt = 1'b1;
              end else begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_SP0;
                cmd.wd_sel = (op_r == OP_PUSH_CONST) ? WD_IMM : WD_LADDR;
                cmd.sp_op  = SP_PUSH;
              end
            end
            OP_PUSH_LVAL: begin
              if (sts.push_ovf) begin
                status_nxt = ST_STACK;
                halted_nxt = 1'b1;
              end else if (!sts.laddr_ok) begin
                status_nxt = ST_ADDR;
                halted_nxt = 1'b1;
              end else begin
                cmd.rd_sel = RD_LOCAL;
                state_nxt  = S_LOC;
              end
            end
            [OP_ASSIGN:OP_AND]: begin
              if (!sts.depth_ge2) begin
                status_nxt = ST_STACK;
                halted_nxt = 1'b1;
              end else begin
                cmd.rd_sel = RD_SP2;
                state_nxt  = S_RD_A;
              end
            end
            default: begin
              status_nxt = ST_ILLEGAL;
              halted_nxt = 1'b1;
            end
          endcase
        end
      end
      S_LOC: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SP0;
        cmd.wd_sel = WD_RD;
        cmd.sp_op  = SP_PUSH;
        state_nxt  = S_TOP;
      end
      S_RD_A: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_sel = RD_SP1;
        state_nxt  = S_RD_B;
      end
      S_RD_B: begin
        cmd.cap_b = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_TOP;
        case (op_r) inside
          OP_ASSIGN: begin
            if (!sts.a_addr_ok) begin
              status_nxt = ST_ADDR;
              halted_nxt = 1'b1;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WR_A;
              cmd.wd_sel = WD_B;
              cmd.sp_op  = SP_POP2;
            end
          end
          OP_MUL: begin
            cmd.md_start = 1'b1;
            state_nxt    = S_MD;
          end
          OP_DIV, OP_MOD: begin
            if (sts.b_zero) begin
              status_nxt = ST_DIVZERO;
              halted_nxt = 1'b1;
            end else begin
              cmd.md_start = 1'b1;
              state_nxt    = S_MD;
            end
          end
          default: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SP2;
            cmd.wd_sel = WD_ALU;
            cmd.sp_op  = SP_POP1;
          end
        endcase
      end
      S_MD: begin
        if (sts.md_done) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_SP2;
          cmd.wd_sel = WD_ALU;
          cmd.sp_op  = SP_POP1;
          state_nxt  = S_TOP;
        end
      end
      S_TOP: begin
        cmd.rd_sel = RD_SP1;
        state_nxt  = S_TOPW;
      end
      S_TOPW: begin
        // hold the read address until the output register frees up
        cmd.rd_sel = RD_SP1;
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= ST_OK;
      op_r        <= OP_NOP;
    end else begin
      state_r     <= state_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      op_r        <= op_nxt;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(halted_r))
    else $error("halt flag cleared without reset");

  a_no_write_halted: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !cmd.wr_en)
    else $error("memory written while halted");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.md_start && (op_r == OP_DIV || op_r == OP_MOD)) |-> !sts.b_zero)
    else $error("divider started with zero divisor");

endmodule

`default_nettype wire

// ===== rtl/sbe_dpath.sv =====
// Datapath of the stack bytecode executor: word memory, stack pointer, config
// registers, ALU, result registers. Depends on sbe_pkg and sbe_muldiv.
`default_nettype none

module sbe_dpath import sbe_pkg::*; #(
  parameter int MEM_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire sbe_cmd_t    cmd,
  output sbe_sts_t         sts,
  input  wire logic [63:0] in_immediate,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_wdata,
  output logic [2:0]       out_status,
  output logic [63:0]      out_top_value,
  output logic [10:0]      out_stack_depth
);

  localparam int MEM_BYTES = MEM_WORDS * 8;
  localparam int AW        = $clog2(MEM_WORDS);
  localparam int BW        = $clog2(MEM_BYTES) + 1;
  localparam int SPW       = (BW > 14) ? BW : 14;
  localparam int DW        = SPW - 3;

  logic [63:0]     mem [MEM_WORDS];
  logic [SPW-1:0]  sp_r;
  logic [12:0]     base_r, frame_r;
  logic [63:0]     imm_r, a_r, b_r, rd_data_r;
  logic [AW-1:0]   clr_r;
  logic [2:0]      status_r;
  logic [63:0]     top_r;
  logic [10:0]     depth_out_r;

  logic [DW-1:0]   sp_word, sp_m1, sp_m2, depth;
  logic [SPW-1:0]  sp_diff;
  logic [63:0]     laddr, alu, wd, md_result;
  logic [AW-1:0]   ra, wa;
  logic            md_done;

  assign sp_word = sp_r[SPW-1:3];
  assign sp_m1   = sp_word - DW'(1);
  assign sp_m2   = sp_word - DW'(2);
  assign sp_diff = sp_r - SPW'(base_r);
  assign depth   = sp_diff[SPW-1:3];
  assign laddr   = 64'(frame_r) + imm_r;

  assign sts.clr_last  = (clr_r == AW'(MEM_WORDS - 1));
  assign sts.push_ovf  = (sp_r > SPW'(MEM_BYTES - 8));
  assign sts.laddr_ok  = (laddr[2:0] == 3'd0) && (laddr < 64'(MEM_BYTES));
  assign sts.depth_ge2 = (depth >= DW'(2));
  assign sts.a_addr_ok = (a_r[2:0] == 3'd0) && (a_r < 64'(MEM_BYTES));
  assign sts.b_zero    = (b_r == 64'd0);
  assign sts.md_done   = md_done;

  sbe_muldiv u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.md_start),
    .op     (cmd.op),
    .opnd_a (a_r),
    .opnd_b (b_r),
    .done   (md_done),
    .result (md_result)
  );

  always_comb begin
    case (cmd.op)
      OP_ADD:  alu = a_r + b_r;
      OP_SUB:  alu = a_r - b_r;
      OP_SHL:  alu = a_r << b_r[5:0];
      OP_SHR:  alu = $unsigned($signed(a_r) >>> b_r[5:0]);
      OP_OR:   alu = a_r | b_r;
      OP_XOR:  alu = a_r ^ b_r;
      OP_AND:  alu = a_r & b_r;
      default: alu = md_result;
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_SP2:   ra = sp_m2[AW-1:0];
      RD_LOCAL: ra = laddr[AW+2:3];
      default:  ra = sp_m1[AW-1:0];
    endcase
    case (cmd.wr_sel)
      WR_SP0:  wa = sp_word[AW-1:0];
      WR_SP2:  wa = sp_m2[AW-1:0];
      WR_A:    wa = a_r[AW+2:3];
      default: wa = clr_r;
    endcase
    case (cmd.wd_sel)
      WD_IMM:   wd = imm_r;
      WD_RD:    wd = rd_data_r;
      WD_LADDR: wd = laddr;
      WD_B:     wd = b_r;
      WD_ALU:   wd = alu;
      default:  wd = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wa] <= wd;
    rd_data_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= 13'd4096;
      frame_r <= 13'd0;
      sp_r    <= SPW'(4096);
      clr_r   <= '0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + AW'(1);
      if (cfg_valid && cfg_index == CFG_STACK_BASE) begin
        base_r <= {cfg_wdata[12:3], 3'b000};
        sp_r   <= SPW'({cfg_wdata[12:3], 3'b000});
      end else begin
        case (cmd.sp_op)
          SP_PUSH: sp_r <= sp_r + SPW'(8);
          SP_POP1: sp_r <= sp_r - SPW'(8);
          SP_POP2: sp_r <= sp_r - SPW'(16);
          default: ;
        endcase
      end
      if (cfg_valid && cfg_index == CFG_FRAME_BASE) frame_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) imm_r <= in_immediate;
    if (cmd.cap_a)   a_r   <= rd_data_r;
    if (cmd.cap_b)   b_r   <= rd_data_r;
    if (cmd.out_load) begin
      status_r    <= cmd.out_status;
      top_r       <= (depth != '0) ? rd_data_r : 64'd0;
      depth_out_r <= depth[10:0];
    end
  end

  assign out_status      = status_r;
  assign out_top_value   = top_r;
  assign out_stack_depth = depth_out_r;

endmodule

`default_nettype wire

// ===== rtl/stack_bytecode_executor.sv =====
// Top level of the stack bytecode executor: joins controller and datapath.
// Depends on sbe_pkg, sbe_ctrl, sbe_dpath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one instruction word: in_op and a
//   64-bit in_immediate. Each accepted word gives exactly one result word on the
//   output channel (out_valid/out_ready): out_status, out_top_value (top of the
//   operand stack, zero when empty) and out_stack_depth.
//   Configuration channel (cfg_valid/cfg_ready, always ready): index 0 writes the
//   stack base (low three bits dropped, also empties the stack), index 1 the frame
//   base; other indexes are ignored. Write it only while the block is idle.
//   Each word passes decode, then a read of the new top of stack, before its result
//   is registered; push_local_val adds a read of the local, assign and simple ALU
//   ops add reads of both operands and an execute step, and mul, div and mod run
//   one bit per cycle in the shared multiply/divide unit. One word is in work at a
//   time; the next is taken in the cycle after its result is registered.
//   Reset: the word memory is zeroed by a clearing pass over all MEM_WORDS words
//   (1024 at the default), during which in_ready stays low.
//   Stall: the result register holds while out_ready is low; a next word may
//   still be taken and worked up to its result, which then waits.
//   End and every fault halt the block; later words return status 6 until reset.
`default_nettype none

module stack_bytecode_executor import sbe_pkg::*; #(
  parameter int MEM_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  in_op,
  input  wire logic [63:0] in_immediate,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [63:0]      out_top_value,
  output logic [10:0]      out_stack_depth,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_wdata
);

  sbe_cmd_t cmd;
  sbe_sts_t sts;

  // config writes never stall
  assign cfg_ready = 1'b1;

  sbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbe_dpath #(.MEM_WORDS(MEM_WORDS)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_immediate    (in_immediate),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_status      (out_status),
    .out_top_value   (out_top_value),
    .out_stack_depth (out_stack_depth)
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for stack_bytecode_executor: directed table, then random
// instruction streams over several base settings, then one halting fault.
// Depends on sbe_pkg and the RTL of stack_bytecode_executor only.
`timescale 1ns / 1ps

module tb import sbe_pkg::*; ();

  localparam int MEM_WORDS = 1024;
  localparam int MEM_BYTES = MEM_WORDS * 8;
  localparam logic [63:0] VMAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] VMIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [2:0]  st;
    logic [63:0] top;
    logic [10:0] depth;
  } out_word_t;

  typedef struct packed {
    logic [4:0]  op;
    logic [63:0] imm;
  } instr_t;

  // One row of the directed table; typed-in results apply where fixed is set.
  typedef struct packed {
    logic [4:0]  op;
    logic [63:0] imm;
    bit          fixed;
    out_word_t   res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [4:0]  in_op;
  logic [63:0] in_immediate;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [63:0] out_top_value;
  logic [10:0] out_stack_depth;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_wdata;

  stack_bytecode_executor #(.MEM_WORDS(MEM_WORDS)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_immediate    (in_immediate),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_top_value   (out_top_value),
    .out_stack_depth (out_stack_depth),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Shadow machine state: word memory, stack pointer, halt flag, base registers.
  logic [63:0] shadow_mem [0:MEM_WORDS-1];
  int unsigned sp_bytes;
  int unsigned stack_base;
  int unsigned frame_base;
  bit          halted_flag;

  out_word_t   pending_results[$];
  instr_t      plan_q[$];
  int          errors;
  bit          in_calm;
  bit          out_calm;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic bit addr_good(logic [63:0] a);
    return a[2:0] == 3'd0 && a < 64'(MEM_BYTES);
  endfunction

  // Execute one instruction on the shadow state. With apply clear, only the
  // status is worked out and nothing changes.
  function automatic logic [2:0] exec_instr(logic [4:0] op, logic [63:0] imm, bit apply);
    int unsigned depth;
    int unsigned new_sp;
    int unsigned widx;
    logic [63:0] a, b, r, v, addr;
    bit          wr;
    logic [2:0]  st;
    if (halted_flag) return ST_HALTED;
    depth  = (sp_bytes - stack_base) / 8;
    new_sp = sp_bytes;
    wr     = 1'b0;
    widx   = 0;
    v      = '0;
    st     = ST_OK;
    case (op)
      OP_NOP: ;
      OP_END: st = ST_END;
      OP_PUSH_CONST, OP_PUSH_LVAL, OP_PUSH_LADDR: begin
        addr = 64'(frame_base) + imm;
        if (sp_bytes + 8 > MEM_BYTES) st = ST_STACK;
        else if (op == OP_PUSH_LVAL && !addr_good(addr)) st = ST_ADDR;
        else begin
          if (op == OP_PUSH_CONST) v = imm;
          else if (op == OP_PUSH_LVAL) v = shadow_mem[addr[12:3]];
          else v = addr;
          wr     = 1'b1;
          widx   = sp_bytes / 8;
          new_sp = sp_bytes + 8;
        end
      end
      OP_ASSIGN, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_SHL, OP_SHR,
      OP_OR, OP_XOR, OP_AND: begin
        if (depth < 2) st = ST_STACK;
        else begin
          a = shadow_mem[sp_bytes / 8 - 2];
          b = shadow_mem[sp_bytes / 8 - 1];
          if (op == OP_ASSIGN) begin
            if (!addr_good(a)) st = ST_ADDR;
            else begin
              wr     = 1'b1;
              widx   = a[12:3];
              v      = b;
              new_sp = sp_bytes - 16;
            end
          end else begin
            r = '0;
            case (op)
              OP_ADD: r = a + b;
              OP_SUB: r = a - b;
              OP_MUL: r = a * b;
              OP_DIV, OP_MOD: begin
                if (b == '0) st = ST_DIVZERO;
                // the one quotient that overflows wraps; its remainder is zero
                else if (a == VMIN && b == '1) r = (op == OP_DIV) ? VMIN : '0;
                else if (op == OP_DIV) r = $signed(a) / $signed(b);
                else r = $signed(a) % $signed(b);
              end
              OP_SHL: r = a << b[5:0];
              OP_SHR: r = $signed(a) >>> b[5:0];
              OP_OR:  r = a | b;
              OP_XOR: r = a ^ b;
              default: r = a & b;
            endcase
            if (st == ST_OK) begin
              wr     = 1'b1;
              widx   = sp_bytes / 8 - 2;
              v      = r;
              new_sp = sp_bytes - 8;
            end
          end
        end
      end
      default: st = ST_ILLEGAL;
    endcase
    if (apply) begin
      if (st != ST_OK) halted_flag = 1'b1;
      else begin
        if (wr) shadow_mem[widx] = v;
        sp_bytes = new_sp;
      end
    end
    return st;
  endfunction

  function automatic out_word_t stack_view(logic [2:0] st);
    out_word_t   res;
    int unsigned depth;
    depth     = (sp_bytes - stack_base) / 8;
    res.st    = st;
    res.depth = 11'(depth);
    res.top   = depth > 0 ? shadow_mem[sp_bytes / 8 - 1] : '0;
    return res;
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 7))
      0: return VMAX;
      1: return VMIN;
      2: return '1;
      3: return 64'($urandom_range(0, 70));
      4: return -64'($urandom_range(1, 70));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Present one word, wait for the handshake, then predict its result.
  task automatic send_instr(logic [4:0] op, logic [63:0] imm, bit fixed, out_word_t res);
    int unsigned gap;
    logic [2:0]  st;
    if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_immediate <= imm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    st = exec_instr(op, imm, 1'b1);
    pending_results.push_back(fixed ? res : stack_view(st));
  endtask

  // Write one register once every outstanding result has drained.
  task automatic write_reg(logic [1:0] idx, logic [12:0] data);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_STACK_BASE) begin
      stack_base = data & 13'h1ff8;
      sp_bytes   = stack_base;
    end else if (idx == CFG_FRAME_BASE) begin
      frame_base = data;
    end
  endtask

  // Draw the next well-formed word: short address/assign and load sequences
  // plus single ops; anything that would fault is swapped for a safe op.
  task automatic next_instr(output logic [4:0] op, output logic [63:0] imm);
    int unsigned pick;
    int unsigned w;
    instr_t      ins;
    if (plan_q.size() == 0) begin
      pick = $urandom_range(0, 99);
      w    = $urandom_range(0, MEM_WORDS - 1);
      if (pick < 20) begin
        plan_q.push_back('{OP_PUSH_LADDR, 64'(w * 8) - 64'(frame_base)});
        plan_q.push_back('{OP_PUSH_CONST, rand_value()});
        plan_q.push_back('{OP_ASSIGN, rand_value()});
      end else if (pick < 35) begin
        plan_q.push_back('{OP_PUSH_LVAL, 64'(w * 8) - 64'(frame_base)});
      end else if (pick < 55) begin
        plan_q.push_back('{OP_PUSH_CONST, rand_value()});
      end else begin
        ins.op  = 5'($urandom_range(0, 15));
        ins.imm = rand_value();
        if (ins.op == OP_END) ins.op = OP_NOP;
        plan_q.push_back(ins);
      end
    end
    ins = plan_q.pop_front();
    op  = ins.op;
    imm = ins.imm;
    if (exec_instr(op, imm, 1'b0) != ST_OK) begin
      if ((sp_bytes - stack_base) / 8 >= 2) op = OP_XOR;
      else if (sp_bytes + 8 <= MEM_BYTES) op = OP_PUSH_CONST;
      else op = OP_NOP;
    end
  endtask

  // Result side: stall at random, then compare with the oldest prediction.
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    forever begin
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word expected none got status %0d", $time, out_status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.st) begin
          $display("%0t: status expected %0d got %0d", $time, want.st, out_status);
          errors++;
        end
        if (out_top_value !== want.top) begin
          $display("%0t: top_value expected %h got %h", $time, want.top, out_top_value);
          errors++;
        end
        if (out_stack_depth !== want.depth) begin
          $display("%0t: stack_depth expected %0d got %0d", $time, want.depth,
                   out_stack_depth);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t        rows[$];
    logic [4:0]  op;
    logic [63:0] imm;
    int unsigned count;
    int unsigned wait_cycles;

    errors       = 0;
    in_calm      = 1'b0;
    out_calm     = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_op        <= OP_NOP;
    in_immediate <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= CFG_STACK_BASE;
    cfg_wdata    <= '0;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    stack_base  = 4096;
    frame_base  = 0;
    sp_bytes    = stack_base;
    halted_flag = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: extremes, wrapping divide, every opcode but end, locals.
    rows = '{
      '{OP_NOP,        64'd0,     1'b1, '{ST_OK, 64'd0, 11'd0}},
      '{OP_PUSH_CONST, VMAX,      1'b1, '{ST_OK, VMAX, 11'd1}},
      '{OP_PUSH_CONST, VMIN,      1'b1, '{ST_OK, VMIN, 11'd2}},
      '{OP_PUSH_CONST, '1,        1'b1, '{ST_OK, '1, 11'd3}},
      '{OP_DIV,        64'd0,     1'b1, '{ST_OK, VMIN, 11'd2}},
      '{OP_PUSH_CONST, '1,        1'b1, '{ST_OK, '1, 11'd3}},
      '{OP_MOD,        64'd0,     1'b1, '{ST_OK, 64'd0, 11'd2}},
      '{OP_ADD,        64'd0,     1'b1, '{ST_OK, VMAX, 11'd1}},
      '{OP_PUSH_CONST, 64'd64,    1'b0, '0},
      '{OP_SHL,        64'd0,     1'b0, '0},
      '{OP_PUSH_CONST, 64'd63,    1'b0, '0},
      '{OP_SHR,        64'd0,     1'b0, '0},
      '{OP_PUSH_CONST, -64'd7,    1'b0, '0},
      '{OP_SUB,        64'd0,     1'b0, '0},
      '{OP_PUSH_CONST, -64'd3,    1'b0, '0},
      '{OP_MUL,        64'd0,     1'b0, '0},
      '{OP_PUSH_CONST, 64'h5555_5555_5555_5555, 1'b0, '0},
      '{OP_OR,         64'd0,     1'b0, '0},
      '{OP_PUSH_CONST, 64'h0f0f_0f0f_0f0f_0f0f, 1'b0, '0},
      '{OP_XOR,        64'd0,     1'b0, '0},
      '{OP_PUSH_LADDR, 64'd8,     1'b0, '0},
      '{OP_PUSH_CONST, 64'hdead_beef_0123_4567, 1'b0, '0},
      '{OP_ASSIGN,     64'd0,     1'b0, '0},
      '{OP_PUSH_LVAL,  64'd8,     1'b0, '0},
      '{OP_PUSH_LADDR, -64'd8,    1'b0, '0},
      '{OP_AND,        64'd0,     1'b0, '0}
    };
    foreach (rows[i]) send_instr(rows[i].op, rows[i].imm, rows[i].fixed, rows[i].res);

    // Random phases, each under its own base settings.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin
          write_reg(CFG_FRAME_BASE, 13'h1fff);
          write_reg(CFG_STACK_BASE, 13'h0000);
        end
        2: begin
          // low bits dropped: the stack has room for one word only
          write_reg(CFG_STACK_BASE, 13'h1fff);
          write_reg(CFG_FRAME_BASE, 13'h0000);
        end
        3: begin
          write_reg(2'd2, 13'($urandom));
          write_reg(2'd3, 13'($urandom));
          write_reg(CFG_STACK_BASE, 13'($urandom_range(0, 1023) * 8));
          write_reg(CFG_FRAME_BASE, 13'($urandom));
        end
        4: begin
          write_reg(CFG_STACK_BASE, 13'h0a5a);
          write_reg(CFG_FRAME_BASE, 13'h0008);
        end
        default: ;
      endcase
      plan_q.delete();
      count = (phase == 2) ? 60 : 240;
      repeat (count) begin
        next_instr(op, imm);
        send_instr(op, imm, 1'b0, '0);
      end
    end

    // Halt with end or a fault drawn at random, then show that the block stays halted.
    write_reg(CFG_STACK_BASE, 13'd4096);
    case ($urandom_range(0, 5))
      0: send_instr(OP_END, rand_value(), 1'b0, '0);
      1, 5: begin
        send_instr(OP_PUSH_CONST, 64'd5, 1'b0, '0);
        send_instr(OP_PUSH_CONST, 64'd0, 1'b0, '0);
        send_instr($urandom_range(0, 1) ? OP_DIV : OP_MOD, 64'd0, 1'b0, '0);
      end
      2: send_instr(5'($urandom_range(16, 31)), rand_value(), 1'b0, '0);
      3: send_instr(OP_ADD, 64'd0, 1'b0, '0);
      default: send_instr(OP_PUSH_LVAL, 64'h4000, 1'b0, '0);
    endcase
    repeat (12) send_instr(5'($urandom_range(0, 31)), rand_value(), 1'b0, '0);
    write_reg(CFG_FRAME_BASE, 13'($urandom));
    repeat (4) send_instr(5'($urandom_range(0, 31)), rand_value(), 1'b0, '0);
    in_valid <= 1'b0;

    // Drain, then keep watching for any stray word.
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
